// ===== sv/csh_pkg.sv =====
// ----------------------------------------------------------------------------
// csh_pkg: shared types and constants for the set-associative LRU cache
// Geometry of the cache and backing store, and the item structs.
// ----------------------------------------------------------------------------
package csh_pkg;

  localparam int SETS        = 16;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int MEM_BYTES   = 65536;

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 32;
  localparam int WPB       = BLOCK_BYTES / 4;
  localparam int WOFF_W    = $clog2(WPB);
  localparam int SET_W     = $clog2(SETS);
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W     = ADDR_W - SET_W - WOFF_W - 2;
  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int LINE_AW   = SET_W + WAY_W + WOFF_W;
  localparam int LINE_WORDS = SETS * WAYS * WPB;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              wrote_back;
  } out_item_t;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
  typedef logic [WAYS-1:0][WAY_W-1:0] lru_row_t;

endpackage

// ===== sv/csh_ram.sv =====
// ----------------------------------------------------------------------------
// csh_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module csh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/set_assoc_lru_cache.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache: 4-way set-associative cache, LRU, write-back/through
// Line and backing RAM ports move one word a cycle during write-back and
// fill, after a priming step for each block transfer.
// One item at a time; the next is taken in the idle cycle after the result is
// registered.
// After reset the backing RAM is swept, one word a cycle, over all 16384 words
// before the first item is taken; config writes are taken throughout.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache
  import csh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_WB, S_FILL, S_ACCESS, S_RESP
  } state_t;

  state_t                state_r, state_nxt;
  logic [MEM_AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [WOFF_W:0]       cnt_r, cnt_nxt;
  in_item_t              req_r, req_nxt;
  logic [WAY_W-1:0]      way_r, way_nxt;
  logic                  hit_r, hit_nxt;
  logic                  wb_r, wb_nxt;
  logic [TAG_W-1:0]      old_tag_r, old_tag_nxt;
  logic                  wt_r;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SETS-1:0][WAYS-1:0] valid_r, valid_nxt;
  logic [SETS-1:0][WAYS-1:0] dirty_r, dirty_nxt;
  lru_row_t [SETS-1:0]   lru_r, lru_nxt;

  logic [SET_W-1:0]  req_set;
  logic [TAG_W-1:0]  req_tag;
  logic [WOFF_W-1:0] req_woff;
  logic [WOFF_W:0]   cnt_m1;

  // tag RAM
  logic             tag_we;
  tag_row_t         tag_wdata, tag_rdata;
  logic [SET_W-1:0] tag_raddr;

  // line data RAM
  logic               line_we;
  logic [LINE_AW-1:0] line_waddr, line_raddr;
  logic [DATA_W-1:0]  line_wdata, line_rdata;

  // backing RAM
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  // lookup results
  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             inv_found;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] sel_way;
  logic [WAY_W-1:0] pos;
  lru_row_t         cur_lru, new_lru;

  assign req_set  = req_r.address[WOFF_W+2 +: SET_W];
  assign req_tag  = req_r.address[ADDR_W-1 -: TAG_W];
  assign req_woff = req_r.address[2 +: WOFF_W];
  assign cnt_m1   = cnt_r - 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  csh_ram #(.WIDTH(WAYS*TAG_W), .DEPTH(SETS)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(req_set), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  csh_ram #(.WIDTH(DATA_W), .DEPTH(LINE_WORDS)) u_line_ram (
    .clk(clk), .we(line_we), .waddr(line_waddr), .wdata(line_wdata),
    .raddr(line_raddr), .rdata(line_rdata)
  );

  csh_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // hit search and victim choice, lowest way first; with no invalid way the LRU way is the victim
  always_comb begin
    hit_found = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_r[req_set][i] && tag_rdata[i] == req_tag) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
      if (!valid_r[req_set][i]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(i);
      end
    end
    cur_lru = lru_r[req_set];
    if (hit_found) begin
      sel_way = hit_way;
    end else if (inv_found) begin
      sel_way = inv_way;
    end else begin
      sel_way = cur_lru[0];
    end
    // move sel_way to the MRU end
    pos = WAY_W'(WAYS - 1);
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (cur_lru[i] == sel_way) begin
        pos = WAY_W'(i);
      end
    end
    for (int i = 0; i < WAYS - 1; i++) begin
      if (WAY_W'(i) >= pos) begin
        new_lru[i] = cur_lru[i+1];
      end else begin
        new_lru[i] = cur_lru[i];
      end
    end
    new_lru[WAYS-1] = sel_way;
  end

  // RAM port control
  always_comb begin
    tag_raddr = (state_r == S_IDLE) ? in_data.address[WOFF_W+2 +: SET_W] : req_set;
    tag_we    = (state_r == S_LOOKUP) && !hit_found;
    tag_wdata = tag_rdata;
    tag_wdata[sel_way] = req_tag;

    line_raddr = (state_r == S_WB) ? {req_set, way_r, cnt_r[WOFF_W-1:0]}
                                   : {req_set, way_r, req_woff};
    line_we    = 1'b0;
    line_waddr = {req_set, way_r, req_woff};
    line_wdata = req_r.write_data;
    if (state_r == S_FILL && cnt_r != '0) begin
      line_we    = 1'b1;
      line_waddr = {req_set, way_r, cnt_m1[WOFF_W-1:0]};
      line_wdata = mem_rdata;
    end else if (state_r == S_ACCESS && req_r.operation) begin
      line_we = 1'b1;
    end

    mem_raddr = {req_tag, req_set, cnt_r[WOFF_W-1:0]};
    mem_we    = 1'b0;
    mem_waddr = req_r.address[ADDR_W-1:2];
    mem_wdata = req_r.write_data;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = DATA_W'({clr_cnt_r, 2'b00});
      end
      S_WB: begin
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = {old_tag_r, req_set, cnt_m1[WOFF_W-1:0]};
          mem_wdata = line_rdata;
        end
      end
      S_ACCESS: begin
        mem_we = req_r.operation && wt_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    way_nxt       = way_r;
    hit_nxt       = hit_r;
    wb_nxt        = wb_r;
    old_tag_nxt   = old_tag_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    lru_nxt       = lru_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == MEM_AW'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        way_nxt          = sel_way;
        hit_nxt          = hit_found;
        old_tag_nxt      = tag_rdata[sel_way];
        lru_nxt[req_set] = new_lru;
        cnt_nxt          = '0;
        wb_nxt           = 1'b0;
        if (hit_found) begin
          state_nxt = S_ACCESS;
        end else begin
          valid_nxt[req_set][sel_way] = 1'b1;
          dirty_nxt[req_set][sel_way] = 1'b0;
          if (valid_r[req_set][sel_way] && dirty_r[req_set][sel_way]) begin
            wb_nxt    = 1'b1;
            state_nxt = S_WB;
          end else begin
            state_nxt = S_FILL;
          end
        end
      end
      S_WB: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (WOFF_W+1)'(WPB)) begin
          cnt_nxt   = '0;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (WOFF_W+1)'(WPB)) begin
          state_nxt = S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (req_r.operation && !wt_r) begin
          dirty_nxt[req_set][way_r] = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.read_data  = req_r.operation ? '0 : line_rdata;
          out_nxt.hit        = hit_r;
          out_nxt.wrote_back = wb_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      wt_r        <= 1'b0;
      valid_r     <= '0;
      dirty_r     <= '0;
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          lru_r[s][w] <= WAY_W'(w);
        end
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      lru_r       <= lru_nxt;
      if (cfg_we) begin
        wt_r <= cfg_wdata;
      end
    end
    req_r     <= req_nxt;
    way_r     <= way_nxt;
    hit_r     <= hit_nxt;
    wb_r      <= wb_nxt;
    old_tag_r <= old_tag_nxt;
    out_r     <= out_nxt;
  end

  // a hit never evicts
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> !out_data.wrote_back)
    else $error("hit result reports a write-back");

  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_LOOKUP)
    else $error("accepted item did not start a lookup");

  // a victim never shares the new line's tag
  a_wb_tag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB |-> old_tag_r != req_tag)
    else $error("write-back of the line being filled");

endmodule
